// File: rtl/bf_pkg.sv
// bf_pkg: shared widths, types and divider tables of the box filter
// no dependencies
package bf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int RAD_W      = 3;
    localparam int KW         = 4;
    localparam int PIX_W      = 8;
    localparam int CSUM_W     = 12;
    localparam int WSUM_W     = 16;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SH   = 24;
    localparam int DIV_W      = 8;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [0:0] REG_IMAGE_SIZE    = 1'b0;
    localparam logic [0:0] REG_KERNEL_RADIUS = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd1024;
    localparam logic [RAD_W-1:0]  RADIUS_RESET = 3'd1;

    typedef struct packed {
        logic              start;
        logic [WSUM_W-1:0] sum;
        logic [RAD_W-1:0]  radius;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quotient;
    } div_rsp_t;

    // floor(2^24 / (2r+1)^2)
    function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] v;
        case (r)
            3'd0:    v = 25'd16777216;
            3'd1:    v = 25'd1864135;
            3'd2:    v = 25'd671088;
            3'd3:    v = 25'd342392;
            3'd4:    v = 25'd207126;
            3'd5:    v = 25'd138654;
            3'd6:    v = 25'd99273;
            default: v = 25'd74565;
        endcase
        return v;
    endfunction

    // (2r+1)^2
    function automatic logic [DIV_W-1:0] area(input logic [RAD_W-1:0] r);
        logic [DIV_W-1:0] v;
        case (r)
            3'd0:    v = 8'd1;
            3'd1:    v = 8'd9;
            3'd2:    v = 8'd25;
            3'd3:    v = 8'd49;
            3'd4:    v = 8'd81;
            3'd5:    v = 8'd121;
            3'd6:    v = 8'd169;
            default: v = 8'd225;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/bf_if.sv
// bf_if: pixel and result stream interfaces
// depends on bf_pkg
interface bf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bf_pkg::PIX_W-1:0]  pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bf_res_if;
    logic                      valid;
    logic                      ready;
    logic [bf_pkg::PIX_W-1:0]  mean_value;
    logic [bf_pkg::POS_W-1:0]  out_row;
    logic [bf_pkg::POS_W-1:0]  out_col;
    logic                      last;
    modport source (output valid, output mean_value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input mean_value, input out_row, input out_col,
                    input last, output ready);
endinterface

// File: rtl/box_filter_mean.sv
// box_filter_mean: top level of the 2d box mean filter
// depends on bf_pkg, bf_if, bf_ram, bf_cell, bf_div
//
//  channel   dir   word                                  accepted when
//  pix_in    in    pixel                                 valid && ready
//  res_out   out   mean_value, out_row, out_col, last    valid && ready
//  apb       in    image_size @0x0, kernel_radius @0x4   psel && penable && pwrite
//
// each pixel gets a ram read and the column/window update; a pixel that closes a
// window then waits on the reciprocal divider, then on the output load
// a result sits in the output register while the next pixel is taken
// a full output register holds the finished mean until res_out is free
// reset sets 1024x1024, radius 1, position 0; a register write restarts the image
module box_filter_mean (
    input  logic                        clk,
    input  logic                        rst_n,
    bf_pix_if.sink                      pix_in,
    bf_res_if.source                    res_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bf_pkg::ADDR_W-1:0]   paddr,
    input  logic [bf_pkg::DATA_W-1:0]   pwdata,
    output logic [bf_pkg::DATA_W-1:0]   prdata,
    output logic                        pready
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int RING_DEPTH = bf_pkg::RING_ROWS * bf_pkg::MAX_WIDTH;

    logic [1:0]                   state_reg, state_next;
    logic [bf_pkg::SIZE_W-1:0]    size_reg;
    logic [bf_pkg::RAD_W-1:0]     radius_reg;
    logic [bf_pkg::POS_W-1:0]     cnt_row_reg, cnt_col_reg;
    logic [bf_pkg::KW-1:0]        cnt_ring_reg;
    logic [bf_pkg::POS_W-1:0]     row_reg, col_reg;
    logic [bf_pkg::KW-1:0]        ring_reg;
    logic [bf_pkg::PIX_W-1:0]     pix_reg;
    logic [bf_pkg::WSUM_W-1:0]    hsum_reg, hsum_next;
    logic                         out_valid_reg;
    logic [bf_pkg::PIX_W-1:0]     out_mean_reg;
    logic [bf_pkg::POS_W-1:0]     out_row_reg, out_col_reg;
    logic                         out_last_reg;

    logic                         accept, cfg_write, emit, load_out;
    logic [bf_pkg::SIZE_W-1:0]    size_eff;
    logic [bf_pkg::KW-1:0]        kdim, kmax;
    logic [bf_pkg::SIZE_W-1:0]    col_plus, row_plus;
    logic [bf_pkg::CSUM_W-1:0]    vsum_old, vsum_new, tap;
    logic [bf_pkg::PIX_W-1:0]     oldest;
    logic [bf_pkg::CSUM_W-1:0]    chain [bf_pkg::RING_ROWS];
    bf_pkg::div_req_t             div_req;
    bf_pkg::div_rsp_t             div_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == bf_pkg::REG_IMAGE_SIZE)
                       ? {{(bf_pkg::DATA_W-bf_pkg::SIZE_W){1'b0}}, size_reg}
                       : {{(bf_pkg::DATA_W-bf_pkg::RAD_W){1'b0}}, radius_reg};

    assign size_eff = (size_reg == '0) ? 11'd1
                    : (size_reg > 11'(bf_pkg::MAX_WIDTH)) ? 11'(bf_pkg::MAX_WIDTH) : size_reg;
    assign kdim = {radius_reg, 1'b1};
    assign kmax = {radius_reg, 1'b0};

    assign accept   = pix_in.valid && pix_in.ready;
    assign pix_in.ready = (state_reg == ST_IDLE);
    assign col_plus = {1'b0, cnt_col_reg} + 11'd1;
    assign row_plus = {1'b0, cnt_row_reg} + 11'd1;

    // line ring and running column sums
    bf_ram #(.WIDTH(bf_pkg::PIX_W), .DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr ({ring_reg, col_reg}),
        .wdata (pix_reg),
        .raddr ({cnt_ring_reg, cnt_col_reg}),
        .rdata (oldest)
    );

    bf_ram #(.WIDTH(bf_pkg::CSUM_W), .DEPTH(bf_pkg::MAX_WIDTH)) u_csum (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (col_reg),
        .wdata (vsum_new),
        .raddr (cnt_col_reg),
        .rdata (vsum_old)
    );

    always_comb
    begin
        if (row_reg == '0)
        begin
            vsum_new = {{(bf_pkg::CSUM_W-bf_pkg::PIX_W){1'b0}}, pix_reg};
        end
        else if (row_reg < {{(bf_pkg::POS_W-bf_pkg::KW){1'b0}}, kdim})
        begin
            vsum_new = vsum_old + {{(bf_pkg::CSUM_W-bf_pkg::PIX_W){1'b0}}, pix_reg};
        end
        else
        begin
            vsum_new = vsum_old + {{(bf_pkg::CSUM_W-bf_pkg::PIX_W){1'b0}}, pix_reg}
                     - {{(bf_pkg::CSUM_W-bf_pkg::PIX_W){1'b0}}, oldest};
        end
    end

    // column sum chain, newest in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < bf_pkg::RING_ROWS; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_head
                bf_cell u_cell (
                    .clk   (clk),
                    .shift (state_reg == ST_RD),
                    .din   (vsum_new),
                    .dout  (chain[gi])
                );
            end
            else
            begin : g_body
                bf_cell u_cell (
                    .clk   (clk),
                    .shift (state_reg == ST_RD),
                    .din   (chain[gi-1]),
                    .dout  (chain[gi])
                );
            end
        end
    endgenerate

    assign tap = chain[kmax];

    always_comb
    begin
        if (col_reg == '0)
        begin
            hsum_next = {{(bf_pkg::WSUM_W-bf_pkg::CSUM_W){1'b0}}, vsum_new};
        end
        else if (col_reg >= {{(bf_pkg::POS_W-bf_pkg::KW){1'b0}}, kdim})
        begin
            hsum_next = hsum_reg + {{(bf_pkg::WSUM_W-bf_pkg::CSUM_W){1'b0}}, vsum_new}
                      - {{(bf_pkg::WSUM_W-bf_pkg::CSUM_W){1'b0}}, tap};
        end
        else
        begin
            hsum_next = hsum_reg + {{(bf_pkg::WSUM_W-bf_pkg::CSUM_W){1'b0}}, vsum_new};
        end
    end

    assign emit = (row_reg >= {{(bf_pkg::POS_W-bf_pkg::KW){1'b0}}, kmax})
               && (col_reg >= {{(bf_pkg::POS_W-bf_pkg::KW){1'b0}}, kmax});

    assign div_req.start  = (state_reg == ST_RD) && emit;
    assign div_req.sum    = hsum_next;
    assign div_req.radius = radius_reg;

    bf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || res_out.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= bf_pkg::SIZE_RESET;
            radius_reg    <= bf_pkg::RADIUS_RESET;
            cnt_row_reg   <= '0;
            cnt_col_reg   <= '0;
            cnt_ring_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (paddr[2] == bf_pkg::REG_IMAGE_SIZE)
                begin
                    size_reg <= pwdata[bf_pkg::SIZE_W-1:0];
                end
                else
                begin
                    radius_reg <= pwdata[bf_pkg::RAD_W-1:0];
                end
                cnt_row_reg  <= '0;
                cnt_col_reg  <= '0;
                cnt_ring_reg <= '0;
            end
            else if (accept)
            begin
                if (col_plus >= size_eff)
                begin
                    cnt_col_reg <= '0;
                    if (row_plus >= size_eff)
                    begin
                        cnt_row_reg  <= '0;
                        cnt_ring_reg <= '0;
                    end
                    else
                    begin
                        cnt_row_reg  <= row_plus[bf_pkg::POS_W-1:0];
                        cnt_ring_reg <= (cnt_ring_reg == kmax) ? '0 : cnt_ring_reg + 4'd1;
                    end
                end
                else
                begin
                    cnt_col_reg <= col_plus[bf_pkg::POS_W-1:0];
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg  <= cnt_row_reg;
            col_reg  <= cnt_col_reg;
            ring_reg <= cnt_ring_reg;
            pix_reg  <= pix_in.pixel;
        end
        if (state_reg == ST_RD)
        begin
            hsum_reg <= hsum_next;
        end
        if (load_out)
        begin
            out_mean_reg <= div_rsp.quotient;
            out_row_reg  <= row_reg - {{(bf_pkg::POS_W-bf_pkg::RAD_W){1'b0}}, radius_reg};
            out_col_reg  <= col_reg - {{(bf_pkg::POS_W-bf_pkg::RAD_W){1'b0}}, radius_reg};
            out_last_reg <= ({1'b0, row_reg} + 11'd1 == size_eff)
                         && ({1'b0, col_reg} + 11'd1 == size_eff);
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.mean_value = out_mean_reg;
    assign res_out.out_row    = out_row_reg;
    assign res_out.out_col    = out_col_reg;
    assign res_out.last       = out_last_reg;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside the output step");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished while sequencer not waiting");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RD))
        else $error("accepted pixel did not start the ram read");
endmodule

// File: rtl/bf_ram.sv
// bf_ram: generic single write port ram with registered read
// no dependencies
module bf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/bf_cell.sv
// bf_cell: one stage of the column sum chain
// depends on bf_pkg
module bf_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [bf_pkg::CSUM_W-1:0]   din,
    output logic [bf_pkg::CSUM_W-1:0]   dout
);
    logic [bf_pkg::CSUM_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            val_reg <= din;
        end
    end

    assign dout = val_reg;
endmodule

// File: rtl/bf_div.sv
// bf_div: window sum divided by (2r+1)^2, reciprocal multiply and fixup
// depends on bf_pkg
module bf_div (
    input  logic             clk,
    input  logic             rst_n,
    input  bf_pkg::div_req_t req,
    output bf_pkg::div_rsp_t rsp
);
    logic [2:0]                                       stage_reg;
    logic [bf_pkg::WSUM_W+bf_pkg::RECIP_W-1:0]        prod_reg;
    logic [bf_pkg::WSUM_W-1:0]                        sum_reg;
    logic [bf_pkg::DIV_W-1:0]                         d_reg;
    logic [bf_pkg::WSUM_W-1:0]                        q0_reg;
    logic [bf_pkg::WSUM_W+bf_pkg::DIV_W-1:0]          qd_reg;
    logic [bf_pkg::PIX_W-1:0]                         q_reg;
    logic [bf_pkg::WSUM_W-1:0]                        q0_next;
    logic [bf_pkg::WSUM_W+bf_pkg::DIV_W-1:0]          rem;

    assign q0_next = prod_reg[bf_pkg::RECIP_SH+bf_pkg::WSUM_W-1:bf_pkg::RECIP_SH];
    assign rem     = {{bf_pkg::DIV_W{1'b0}}, sum_reg} - qd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 3'b000;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= (bf_pkg::WSUM_W+bf_pkg::RECIP_W)'(req.sum)
                        * (bf_pkg::WSUM_W+bf_pkg::RECIP_W)'(bf_pkg::recip(req.radius));
            sum_reg  <= req.sum;
            d_reg    <= bf_pkg::area(req.radius);
        end
        if (stage_reg[0])
        begin
            q0_reg <= q0_next;
            qd_reg <= (bf_pkg::WSUM_W+bf_pkg::DIV_W)'(q0_next)
                      * (bf_pkg::WSUM_W+bf_pkg::DIV_W)'(d_reg);
        end
        if (stage_reg[1])
        begin
            if (rem >= (bf_pkg::WSUM_W+bf_pkg::DIV_W)'(d_reg))
            begin
                q_reg <= q0_reg[bf_pkg::PIX_W-1:0] + 8'd1;
            end
            else
            begin
                q_reg <= q0_reg[bf_pkg::PIX_W-1:0];
            end
        end
    end

    assign rsp.done     = stage_reg[2];
    assign rsp.quotient = q_reg;
endmodule
